// ===== hdl/ssetbl_pkg.sv =====
// Shared types and constants for the sorted set table.
// Operation and status codes, result struct. No dependencies.
package ssetbl_pkg;

  localparam int ValW    = 32;
  localparam int LimitW  = 6;
  localparam int ShowMax = 32;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;
  localparam logic [1:0] FUNC_SHOW   = 2'd3;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                    found;
    logic signed [ValW-1:0]  item;
    logic                    last;
    logic [1:0]              status;
  } res_t;

endpackage

// ===== hdl/ssetbl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ssetbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/ssetbl_outreg.sv =====
// Result output register for the sorted set table.
// Depends on ssetbl_pkg (res_t).
module ssetbl_outreg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ssetbl_pkg::res_t   res,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output ssetbl_pkg::res_t   out_res
);
  import ssetbl_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // free: the register is empty at the next edge unless loaded
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== hdl/sorted_set_table.sv =====
// Sorted set table top level: control sequencer, limit register, entry RAM.
// Depends on ssetbl_pkg, ssetbl_ram, ssetbl_outreg.
//
// Keeps up to CAPACITY signed values in ascending order, no duplicates, in
// one RAM with a registered read. Insert, remove and search walk the stored
// entries through the single read port, one entry per cycle, shifting in
// the same pass with the write port. Show reads each entry and then loads
// it into the output register, waiting while the output side stalls.
// Only one item is in work at a time; in_stall is high while it runs. The
// entry RAM needs no clearing after reset: only entries below count are read.
module sorted_set_table #(
  parameter int CAPACITY = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic signed [31:0]            in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic signed [31:0]            out_item,
  output logic                          out_last,
  output logic [1:0]                    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssetbl_pkg::LimitW-1:0] cfg_list_limit
);
  import ssetbl_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LimitW) ? CW : LimitW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_RESP, S_SHOW_RD, S_SHOW_LD
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [LimitW-1:0]   limit_r, limit_nxt;
  logic [1:0]          func_r, func_nxt;
  logic [ValW-1:0]     value_r, value_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                dv_r, dv_nxt;
  logic [CW-1:0]       d_idx_r, d_idx_nxt;
  logic                placed_r, placed_nxt;
  logic [ValW-1:0]     carry_r, carry_nxt;
  logic                hit_r, hit_nxt;
  logic                full_r, full_nxt;
  logic [CW-1:0]       show_n_r, show_n_nxt;
  logic [CW-1:0]       show_k_r, show_k_nxt;
  logic                resp_found_r, resp_found_nxt;
  logic [1:0]          resp_status_r, resp_status_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ValW-1:0]     ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [ValW-1:0]     ram_rdata;

  logic                res_load;
  res_t                res;
  logic                out_free;
  res_t                out_res;

  logic [LW-1:0]       count_w, limit_w, eff_lim, show_w;
  logic                more, eq, gt;

  ssetbl_ram #(
    .WIDTH(ValW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  ssetbl_outreg u_outreg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_load),
    .res      (res),
    .free     (out_free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_found  = out_res.found;
  assign out_item   = out_res.item;
  assign out_last   = out_res.last;
  assign out_status = out_res.status;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign count_w = LW'(count_r);
  assign limit_w = LW'(limit_r);
  assign eff_lim = (limit_w < LW'(CAPACITY)) ? limit_w : LW'(CAPACITY);
  always_comb begin
    show_w = (count_w < eff_lim) ? count_w : eff_lim;
    if (show_w > LW'(ShowMax)) begin
      show_w = LW'(ShowMax);
    end
  end

  assign more = (rd_idx_r < count_r);
  assign eq   = (ram_rdata == value_r);
  assign gt   = ($signed(ram_rdata) > $signed(value_r));

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    limit_nxt       = limit_r;
    func_nxt        = func_r;
    value_nxt       = value_r;
    rd_idx_nxt      = rd_idx_r;
    dv_nxt          = 1'b0;
    d_idx_nxt       = d_idx_r;
    placed_nxt      = placed_r;
    carry_nxt       = carry_r;
    hit_nxt         = hit_r;
    full_nxt        = full_r;
    show_n_nxt      = show_n_r;
    show_k_nxt      = show_k_r;
    resp_found_nxt  = resp_found_r;
    resp_status_nxt = resp_status_r;
    ram_we          = 1'b0;
    ram_waddr       = d_idx_r[AW-1:0];
    ram_wdata       = carry_r;
    ram_raddr       = rd_idx_r[AW-1:0];
    res_load        = 1'b0;
    res             = '{found: resp_found_r, item: '0, last: 1'b1, status: resp_status_r};

    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_list_limit;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          value_nxt  = in_value;
          rd_idx_nxt = '0;
          placed_nxt = 1'b0;
          hit_nxt    = 1'b0;
          full_nxt   = (count_w >= eff_lim);
          show_n_nxt = show_w[CW-1:0];
          show_k_nxt = '0;
          if (in_func == FUNC_SHOW) begin
            if (show_w == '0) begin
              resp_found_nxt  = 1'b0;
              resp_status_nxt = STATUS_EMPTY;
              state_nxt       = S_RESP;
            end else begin
              state_nxt = S_SHOW_RD;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (more) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          dv_nxt     = 1'b1;
          d_idx_nxt  = rd_idx_r;
        end
        if (dv_r) begin
          unique case (func_r)
            FUNC_INSERT: begin
              if (!placed_r && eq) begin
                resp_found_nxt  = 1'b1;
                resp_status_nxt = STATUS_DONE;
                dv_nxt          = 1'b0;
                state_nxt       = S_RESP;
              end else if (!full_r) begin
                if (placed_r) begin
                  ram_we    = 1'b1;
                  ram_wdata = carry_r;
                  carry_nxt = ram_rdata;
                end else if (gt) begin
                  ram_we     = 1'b1;
                  ram_wdata  = value_r;
                  carry_nxt  = ram_rdata;
                  placed_nxt = 1'b1;
                end
              end
            end
            FUNC_REMOVE: begin
              if (hit_r) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(d_idx_r - CW'(1));
                ram_wdata = ram_rdata;
              end else if (eq) begin
                hit_nxt = 1'b1;
              end
            end
            FUNC_SEARCH: begin
              if (eq) begin
                resp_found_nxt  = 1'b1;
                resp_status_nxt = STATUS_DONE;
                dv_nxt          = 1'b0;
                state_nxt       = S_RESP;
              end
            end
            default: begin
            end
          endcase
        end else if (!more) begin
          // walk finished: close out the operation
          resp_found_nxt  = 1'b0;
          resp_status_nxt = STATUS_DONE;
          state_nxt       = S_RESP;
          unique case (func_r)
            FUNC_INSERT: begin
              if (full_r) begin
                resp_status_nxt = STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[AW-1:0];
                ram_wdata = placed_r ? carry_r : value_r;
                count_nxt = count_r + CW'(1);
              end
            end
            FUNC_REMOVE: begin
              resp_found_nxt = hit_r;
              if (hit_r) begin
                count_nxt = count_r - CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RESP: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_SHOW_RD: begin
        ram_raddr = show_k_r[AW-1:0];
        if (out_free) begin
          state_nxt = S_SHOW_LD;
        end
      end

      S_SHOW_LD: begin
        res_load   = 1'b1;
        res        = '{found: 1'b0, item: ram_rdata,
                       last: (show_k_r + CW'(1) == show_n_r), status: STATUS_DONE};
        show_k_nxt = show_k_r + CW'(1);
        state_nxt  = (show_k_r + CW'(1) == show_n_r) ? S_IDLE : S_SHOW_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      limit_r <= LimitW'(32);
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      limit_r <= limit_nxt;
      dv_r    <= dv_nxt;
    end
    func_r        <= func_nxt;
    value_r       <= value_nxt;
    rd_idx_r      <= rd_idx_nxt;
    d_idx_r       <= d_idx_nxt;
    placed_r      <= placed_nxt;
    carry_r       <= carry_nxt;
    hit_r         <= hit_nxt;
    full_r        <= full_nxt;
    show_n_r      <= show_n_nxt;
    show_k_r      <= show_k_nxt;
    resp_found_r  <= resp_found_nxt;
    resp_status_r <= resp_status_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> CW'(ram_waddr) <= count_r)
    else $error("write beyond stored entries");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result loaded over pending item");

  a_empty_show: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_EMPTY) |-> (out_last && !out_found))
    else $error("empty show result malformed");

  a_search_ro: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && func_r == FUNC_SEARCH) |-> !ram_we)
    else $error("search wrote the table");
`endif

endmodule

// ===== tb/ssetbl_checker.sv =====
// Checker for the sorted set table: watches the item, result and limit channels,
// keeps its own copy of the table and compares every result in order.
// Depends on ssetbl_pkg.
module ssetbl_checker #(
  parameter int CAPACITY = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic signed [31:0]            in_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_found,
  input  logic signed [31:0]            out_item,
  input  logic                          out_last,
  input  logic [1:0]                    out_status,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ssetbl_pkg::LimitW-1:0] cfg_list_limit,
  output int                            fails,
  output int                            pending,
  output int                            n_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssetbl_pkg::*;

  logic signed [ValW-1:0] stored [CAPACITY];
  int                     n_stored;
  logic [LimitW-1:0]      limit_reg;
  res_t                   due_results[$];

  initial begin
    fails = 0;
    pending = 0;
    n_checked = 0;
    n_stored = 0;
    limit_reg = 6'd32;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  // Applies one item to the shadow table and queues the results it causes.
  task automatic predict_op(input logic [1:0] func, input logic signed [ValW-1:0] v);
    int   idx;
    int   pos;
    int   lim;
    int   n;
    bit   hit;
    res_t r;
    hit = 1'b0;
    idx = 0;
    for (int i = 0; i < n_stored; i++) begin
      if (!hit && stored[i] == v) begin
        hit = 1'b1;
        idx = i;
      end
    end
    lim = (int'(limit_reg) < CAPACITY) ? int'(limit_reg) : CAPACITY;
    r.found = 1'b0;
    r.item = '0;
    r.last = 1'b1;
    r.status = STATUS_DONE;
    case (func)
      FUNC_INSERT: begin
        if (hit) begin
          r.found = 1'b1;
        end else if (n_stored >= lim) begin
          r.status = STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < n_stored && stored[pos] <= v) pos++;
          for (int j = n_stored; j > pos; j--) stored[j] = stored[j-1];
          stored[pos] = v;
          n_stored++;
        end
        due_results.push_back(r);
      end
      FUNC_REMOVE: begin
        if (hit) begin
          for (int j = idx; j + 1 < n_stored; j++) stored[j] = stored[j+1];
          n_stored--;
        end
        r.found = hit;
        due_results.push_back(r);
      end
      FUNC_SEARCH: begin
        r.found = hit;
        due_results.push_back(r);
      end
      default: begin
        n = (n_stored < lim) ? n_stored : lim;
        if (n > ShowMax) n = ShowMax;
        if (n == 0) begin
          r.status = STATUS_EMPTY;
          due_results.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.item = stored[i];
            r.last = (i == n - 1);
            due_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  task automatic check_result();
    res_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result with none expected (item %0d last %0b status %0d)",
                                out_item, out_last, out_status));
      return;
    end
    want = due_results.pop_front();
    n_checked++;
    if (out_found !== want.found)
      report_mismatch($sformatf("found %b, expected %b", out_found, want.found));
    if (out_item !== want.item)
      report_mismatch($sformatf("item %0d, expected %0d", out_item, want.item));
    if (out_last !== want.last)
      report_mismatch($sformatf("last %b, expected %b", out_last, want.last));
    if (out_status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      n_stored = 0;
      limit_reg = 6'd32;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_valid && cfg_ready) limit_reg = cfg_list_limit;
      if (in_valid && !in_stall) predict_op(in_func, in_value);
    end
    pending = due_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the sorted set table: clock, reset, item and limit stimulus
// with random idling on the item and result channels, and the verdict.
// Depends on ssetbl_pkg, sorted_set_table and ssetbl_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ssetbl_pkg::*;

  localparam int CAPACITY = 32;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_func = FUNC_INSERT;
  logic signed [31:0]  in_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_found;
  logic signed [31:0]  out_item;
  logic                out_last;
  logic [1:0]          out_status;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LimitW-1:0]   cfg_list_limit = '0;

  int fails;
  int pending;
  int n_checked;
  int n_items = 0;
  int stall_left = 0;
  bit calm = 1'b1;
  logic signed [31:0] seen_vals[$];

  always #4 clk = ~clk;

  sorted_set_table #(.CAPACITY(CAPACITY)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
    .out_item(out_item), .out_last(out_last), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_list_limit(cfg_list_limit)
  );

  ssetbl_checker #(.CAPACITY(CAPACITY)) u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
    .out_item(out_item), .out_last(out_last), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_list_limit(cfg_list_limit),
    .fails(fails), .pending(pending), .n_checked(n_checked)
  );

  // result-side backpressure: mostly short stalls, a few long ones
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          stall_left = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end
        4: begin
          stall_left = $urandom_range(8, 24);
          out_stall <= 1'b1;
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      t = $urandom_range(0, 120);
      return t - 60;
    end
    if (r < 75 && seen_vals.size() > 0) return seen_vals[$urandom_range(0, seen_vals.size() - 1)];
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return VMIN;
        1: return VMAX;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_op(input logic [1:0] func, input logic signed [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    n_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (CAPACITY + 8) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] lim);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_list_limit <= lim;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_mix(input int n, input int w_ins, input int w_rem, input int w_srch);
    int r;
    logic [1:0] func;
    logic signed [31:0] v;
    for (int k = 0; k < n; k++) begin
      if (k % 16 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < w_ins) func = FUNC_INSERT;
      else if (r < w_ins + w_rem) func = FUNC_REMOVE;
      else if (r < w_ins + w_rem + w_srch) func = FUNC_SEARCH;
      else func = FUNC_SHOW;
      v = pick_value();
      send_op(func, v);
      if (func == FUNC_INSERT) begin
        seen_vals.push_back(v);
        if (seen_vals.size() > 64) void'(seen_vals.pop_front());
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    #10_000_000;
    $display("timeout with %0d results still due", pending);
    $display("FAIL sorted_set_table");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, ordering at the extremes, duplicates, misses
    send_op(FUNC_SHOW, '0);
    send_op(FUNC_SEARCH, 5);
    send_op(FUNC_REMOVE, 5);
    send_op(FUNC_INSERT, 0);
    send_op(FUNC_INSERT, VMAX);
    send_op(FUNC_INSERT, VMIN);
    send_op(FUNC_INSERT, -1);
    send_op(FUNC_INSERT, 1);
    send_op(FUNC_INSERT, 0);
    send_op(FUNC_SHOW, VMAX);
    send_op(FUNC_SEARCH, VMIN);
    send_op(FUNC_SEARCH, 6);
    send_op(FUNC_REMOVE, 0);
    send_op(FUNC_REMOVE, VMIN);
    send_op(FUNC_REMOVE, VMAX);
    send_op(FUNC_REMOVE, 0);
    send_op(FUNC_SHOW, '0);

    // full table, duplicate ahead of full, limit below count, zero limit
    write_limit(6'd2);
    send_op(FUNC_INSERT, 7);
    send_op(FUNC_INSERT, -1);
    send_op(FUNC_SHOW, '0);
    write_limit(6'd1);
    send_op(FUNC_SHOW, '0);
    send_op(FUNC_SEARCH, 1);
    send_op(FUNC_REMOVE, 1);
    send_op(FUNC_INSERT, 9);
    send_op(FUNC_REMOVE, -1);
    write_limit(6'd0);
    send_op(FUNC_SHOW, '0);
    send_op(FUNC_INSERT, 3);

    write_limit(6'd20);
    run_mix(45, 65, 10, 10);
    write_limit(6'd5);
    run_mix(35, 30, 35, 20);
    write_limit(6'd63);
    run_mix(45, 70, 5, 10);
    write_limit(6'd32);
    run_mix(15, 40, 25, 20);

    wait_drained();
    $display("Summary: %0d items under list limits 0, 1, 2, 5, 20, 32 and 63", n_items);
    $display("Summary: %0d results compared, %0d mismatches", n_checked, fails);
    if (fails == 0) begin
      $display("PASS sorted_set_table");
    end else begin
      $display("FAIL sorted_set_table");
    end
    $finish;
  end

endmodule
